// File: rtl/core/mcsp_pkg.sv
// ----------------------------------------------------------------------------
// mcsp_pkg: shared definitions for the servo pulse generator
// Types, codes and constants used by the channel cells and the top level.
// ----------------------------------------------------------------------------
package mcsp_pkg;

  // Field and register widths
  localparam int LEVEL_W   = 22;
  localparam int CHAN_W    = 5;
  localparam int PCT_W     = 8;
  localparam int WIDTH_W   = 12;
  localparam int TICK_W    = 16;
  localparam int GAIN_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Defaults and limits
  localparam int                   CHANNELS_DEF      = 22;
  localparam logic [TICK_W-1:0]    PERIOD_RESET      = 16'd20000;
  localparam logic [WIDTH_W-1:0]   CENTER_RESET      = 12'd1500;
  localparam logic [GAIN_W-1:0]    GAIN_RESET        = 4'd4;
  localparam logic signed [PCT_W-1:0] PERCENT_LIMIT  = 8'sd100;
  localparam logic [WIDTH_W-1:0]   WIDTH_MAX         = 12'd4095;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_PUBLISH = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAN = 2'd1,
    STATUS_BAD_PCT  = 2'd2
  } status_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_CENTER = 2'd1,
    REG_GAIN   = 2'd2
  } reg_idx_t;

  // Command broadcast from the top level to every channel cell
  typedef struct packed {
    logic               stage_we;
    logic [WIDTH_W-1:0] stage_width;
    logic               copy;
    logic [TICK_W-1:0]  tick_count;
  } cell_cmd_t;

  // One result beat
  typedef struct packed {
    logic [LEVEL_W-1:0] pin_levels;
    logic               frame_start;
    logic [1:0]         status;
  } result_t;

endpackage

// File: rtl/core/mcsp_cell.sv
// ----------------------------------------------------------------------------
// mcsp_cell: one servo channel
// Holds the staged and active pulse width of a channel, computes its pin level
// for the current tick and shifts it into the level vector handed down the row.
// ----------------------------------------------------------------------------
module mcsp_cell
  import mcsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stage_sel,
  input  cell_cmd_t          cmd,
  input  logic [LEVEL_W-1:0] levels_in,
  output logic [LEVEL_W-1:0] levels_out
);

  logic [WIDTH_W-1:0] staged_r, staged_nxt;
  logic [WIDTH_W-1:0] active_r, active_nxt;
  logic [WIDTH_W-1:0] active_now;
  logic               level;

  // The width seen on this tick already includes a copy taken at frame start.
  always_comb begin
    active_now = cmd.copy ? staged_r : active_r;
    active_nxt = active_now;
    staged_nxt = (cmd.stage_we && stage_sel) ? cmd.stage_width : staged_r;
    level      = (active_now != '0) && ({4'd0, active_now} > cmd.tick_count);
  end

  // Shift this channel's level in below those of the higher channels.
  assign levels_out = {levels_in[LEVEL_W-2:0], level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staged_r <= '0;
      active_r <= '0;
    end else begin
      staged_r <= staged_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: rtl/core/multi_channel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator: servo pulse frames for many channels
// A row of channel cells driven by one item stream and one tick counter.
// ----------------------------------------------------------------------------
// Usage: every input beat is a tick of one microsecond, a channel setting or
// a publish request, selected by in_mode. Each accepted beat yields exactly
// one result beat on the out_ channel: the pin levels held after the beat, a
// frame start flag and a status code for channel settings.
// The result is registered. Throughput is one beat per cycle while the skid
// register is empty; every channel cell evaluates its comparison in parallel,
// so the cycle time is set by the width arithmetic and the per-cell compare.
// A two-entry output stage (result register plus skid register) lets the
// block keep accepting while the receiver stalls; in_ready drops only when
// both entries are full.
// Configuration writes on the cfg_ channel are always taken and must only
// happen while the block is idle. After reset the registers hold their
// defaults, all channels are off, the tick counter is zero and a publish is
// pending so the first frame copies the staged widths.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_generator
  import mcsp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  // Input item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [CHAN_W-1:0]           in_channel_index,
  input  logic signed [PCT_W-1:0]     in_percent,
  input  logic                        in_turn_off,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [LEVEL_W-1:0]          out_pin_levels,
  output logic                        out_frame_start,
  output logic [1:0]                  out_status
);

  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W+1)'(CHANNELS);

  // Configuration registers
  logic [TICK_W-1:0]  period_r;
  logic [WIDTH_W-1:0] center_r;
  logic [GAIN_W-1:0]  gain_r;

  // Frame state
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic               pending_r, pending_nxt;
  logic [LEVEL_W-1:0] held_r, held_nxt;

  // Output stage
  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  result_t res;

  logic                     accept;
  mode_t                    mode;
  cell_cmd_t                cmd;
  logic [CHANNELS-1:0]      stage_sel;
  logic [LEVEL_W-1:0]       lv [0:CHANNELS];
  logic signed [13:0]       gain_ext;
  logic signed [13:0]       pct_ext;
  logic signed [13:0]       width_raw;
  logic [WIDTH_W-1:0]       width_sat;
  logic [TICK_W-1:0]        tick_inc;
  logic                     frame_start;
  logic                     pct_bad;
  logic                     chan_bad;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign mode      = mode_t'(in_mode);

  // Configuration register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      center_r <= CENTER_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD: period_r <= cfg_data;
        REG_CENTER: center_r <= cfg_data[WIDTH_W-1:0];
        REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Width of a set item: centre plus gain times percent, saturated to 1..4095.
  // Both factors are widened to the full sum width before the product.
  always_comb begin
    gain_ext  = $signed({10'd0, gain_r});
    pct_ext   = {{6{in_percent[PCT_W-1]}}, in_percent};
    width_raw = $signed({2'b00, center_r}) + gain_ext * pct_ext;
    if (width_raw < 14'sd1) begin
      width_sat = 12'd1;
    end else if (width_raw > $signed({2'b00, WIDTH_MAX})) begin
      width_sat = WIDTH_MAX;
    end else begin
      width_sat = width_raw[WIDTH_W-1:0];
    end
  end

  assign chan_bad    = {1'b0, in_channel_index} >= CHAN_LIMIT;
  assign pct_bad     = (in_percent < -PERCENT_LIMIT) || (in_percent > PERCENT_LIMIT);
  assign frame_start = (tick_r == '0);
  assign tick_inc    = tick_r + 16'd1;

  // Decode the item into a cell command and the next frame state.
  always_comb begin
    cmd.stage_we    = 1'b0;
    cmd.stage_width = in_turn_off ? '0 : width_sat;
    cmd.copy        = 1'b0;
    cmd.tick_count  = tick_r;
    tick_nxt        = tick_r;
    pending_nxt     = pending_r;
    held_nxt        = held_r;
    res.status      = STATUS_OK;
    res.frame_start = 1'b0;
    case (mode)
      MODE_TICK: begin
        cmd.copy        = accept && frame_start && pending_r;
        res.frame_start = frame_start;
        held_nxt        = lv[0];
        tick_nxt        = (tick_inc >= period_r) ? '0 : tick_inc;
        if (frame_start) begin
          pending_nxt = 1'b0;
        end
      end
      MODE_SET: begin
        if (chan_bad) begin
          res.status = STATUS_BAD_CHAN;
        end else if (!in_turn_off && pct_bad) begin
          res.status = STATUS_BAD_PCT;
        end else begin
          cmd.stage_we = accept;
        end
      end
      MODE_PUBLISH: begin
        pending_nxt = 1'b1;
      end
      default: ;
    endcase
    res.pin_levels = held_nxt;
  end

  // Row of channel cells; the level vector is handed from the highest
  // channel down to channel zero.
  assign lv[CHANNELS] = '0;

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_cell
      assign stage_sel[g] = (in_channel_index == CHAN_W'(g));
      mcsp_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_sel  (stage_sel[g]),
        .cmd        (cmd),
        .levels_in  (lv[g+1]),
        .levels_out (lv[g])
      );
    end
  endgenerate

  // Frame state registers, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      pending_r <= 1'b1;
      held_r    <= '0;
    end else if (accept) begin
      tick_r    <= tick_nxt;
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

  // Output stage: a result register backed by a skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_valid_r && !out_ready) begin
      if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      main_valid_r <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid_r && !out_ready) begin
      if (accept) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      main_r <= skid_r;
    end else if (accept) begin
      main_r <= res;
    end
  end

  assign out_valid       = main_valid_r;
  assign out_pin_levels  = main_r.pin_levels;
  assign out_frame_start = main_r.frame_start;
  assign out_status      = main_r.status;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multi-channel servo pulse generator
// Drives tick, set and publish beats with random gaps and back-pressure,
// predicts every result beat with an independent copy of the channel state
// and compares each result field with the oldest predicted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mcsp_pkg::*;

  localparam int NUM_CH  = CHANNELS_DEF;
  localparam int PCT_MAX = 100;
  localparam int MAX_SHOWN = 10;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One input beat as the sender sees it
  typedef struct packed {
    mode_t                   mode;
    logic [CHAN_W-1:0]       chan;
    logic signed [PCT_W-1:0] pct;
    logic                    off;
  } servo_cmd_t;

  // Block ports
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_mode = '0;
  logic [CHAN_W-1:0]       in_channel_index = '0;
  logic signed [PCT_W-1:0] in_percent = '0;
  logic                    in_turn_off = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [LEVEL_W-1:0]      out_pin_levels;
  logic                    out_frame_start;
  logic [1:0]              out_status;

  // Predicted channel state and register copies
  logic [WIDTH_W-1:0] staged_w [NUM_CH];
  logic [WIDTH_W-1:0] live_w [NUM_CH];
  logic               copy_armed;
  logic [TICK_W-1:0]  tick_pos;
  logic [LEVEL_W-1:0] held_pins;
  logic [TICK_W-1:0]  period_reg;
  logic [WIDTH_W-1:0] center_reg;
  logic [GAIN_W-1:0]  gain_reg;

  // Result beats still owed by the block, oldest first
  result_t awaited_beats[$];
  result_t want_beat;

  // Run control and tallies
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit in_offering = 1'b0;
  int rx_hold_len = 0;
  int err_count = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int frames_seen = 0;
  int rejects_seen = 0;
  int settings_used = 0;

  multi_channel_servo_pulse_generator #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_channel_index (in_channel_index),
    .in_percent       (in_percent),
    .in_turn_off      (in_turn_off),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pin_levels   (out_pin_levels),
    .out_frame_start  (out_frame_start),
    .out_status       (out_status)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Generous upper bound on the whole run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Put the predicted state into its post-reset condition.
  function automatic void clear_predictor();
    for (int i = 0; i < NUM_CH; i++) begin
      staged_w[i] = '0;
      live_w[i]   = '0;
    end
    copy_armed = 1'b1;
    tick_pos   = '0;
    held_pins  = '0;
    period_reg = PERIOD_RESET;
    center_reg = CENTER_RESET;
    gain_reg   = GAIN_RESET;
  endfunction

  // Advance the predicted state by one beat and return the result it causes.
  function automatic result_t predict_pins(servo_cmd_t c);
    result_t            r;
    int                 p;
    int                 w;
    logic [LEVEL_W-1:0] lv;
    logic [TICK_W-1:0]  nxt;
    r = '0;
    p = int'($signed(c.pct));
    case (c.mode)
      MODE_TICK: begin
        // A frame starts when the counter sits at zero; an armed copy lands first.
        if (tick_pos == '0) begin
          r.frame_start = 1'b1;
          if (copy_armed) begin
            live_w = staged_w;
            copy_armed = 1'b0;
          end
        end
        lv = '0;
        for (int i = 0; i < NUM_CH; i++) begin
          if (live_w[i] != '0 && tick_pos < live_w[i]) lv[i] = 1'b1;
        end
        held_pins = lv;
        nxt = tick_pos + 1'b1;
        if (nxt >= period_reg) nxt = '0;
        tick_pos = nxt;
      end
      MODE_SET: begin
        // The channel is checked before the percent; an off request skips the latter.
        if (c.chan >= NUM_CH) begin
          r.status = STATUS_BAD_CHAN;
        end else if (c.off) begin
          staged_w[c.chan] = '0;
        end else if (p < -PCT_MAX || p > PCT_MAX) begin
          r.status = STATUS_BAD_PCT;
        end else begin
          w = int'(center_reg) + int'(gain_reg) * p;
          if (w < 1) w = 1;
          if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
          staged_w[c.chan] = w[WIDTH_W-1:0];
        end
      end
      MODE_PUBLISH: begin
        copy_armed = 1'b1;
      end
      default: begin
      end
    endcase
    r.pin_levels = held_pins;
    return r;
  endfunction

  function automatic servo_cmd_t make_cmd(mode_t m, int ch, int p, bit off);
    servo_cmd_t c;
    c.mode = m;
    c.chan = CHAN_W'(ch);
    c.pct  = PCT_W'(p);
    c.off  = off;
    return c;
  endfunction

  // Mostly well-formed traffic, with a tail of rejected and unused beats.
  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    int         k;
    c.chan = CHAN_W'($urandom_range(0, 31));
    c.pct  = PCT_W'($urandom_range(0, 255));
    c.off  = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 99);
    if (k < 58) begin
      c.mode = MODE_TICK;
    end else if (k < 84) begin
      c.mode = MODE_SET;
      c.chan = CHAN_W'($urandom_range(0, NUM_CH - 1));
      c.pct  = PCT_W'($urandom_range(0, 2 * PCT_MAX) - PCT_MAX);
      c.off  = ($urandom_range(0, 7) == 0);
    end else if (k < 92) begin
      c.mode = MODE_PUBLISH;
    end else if (k < 95) begin
      c.mode = MODE_SET;
      c.chan = CHAN_W'($urandom_range(NUM_CH, 31));
    end else if (k < 98) begin
      // Percent outside the legal span, on either side.
      c.mode = MODE_SET;
      c.chan = CHAN_W'($urandom_range(0, NUM_CH - 1));
      c.off  = 1'b0;
      c.pct  = $urandom_range(0, 1) ? PCT_W'($urandom_range(PCT_MAX + 1, 127))
                                    : PCT_W'($urandom_range(128, 255 - PCT_MAX));
    end else begin
      c.mode = MODE_UNUSED;
    end
    return c;
  endfunction

  function automatic void report_fault(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= MAX_SHOWN)
      $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  // Drop the input valid once, and only if it is currently being offered.
  task automatic release_input();
    if (in_offering) begin
      in_valid <= 1'b0;
      in_offering = 1'b0;
    end
  endtask

  // Offer one beat, wait for it to be taken and record its predicted result.
  task automatic send_cmd(servo_cmd_t c);
    result_t r;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      release_input();
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= c.mode;
    in_channel_index <= c.chan;
    in_percent       <= c.pct;
    in_turn_off      <= c.off;
    in_offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_pins(c);
    awaited_beats.push_back(r);
    items_sent++;
    if (c.mode == MODE_TICK) ticks_sent++;
    if (r.frame_start) frames_seen++;
    if (r.status != STATUS_OK) rejects_seen++;
  endtask

  // Stop offering and wait until every owed result beat has arrived.
  task automatic wait_drained();
    release_input();
    while (awaited_beats.size() != 0) @(posedge clk);
  endtask

  // Register write, issued only once the block has gone quiet.
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PERIOD: period_reg = val;
      REG_CENTER: center_reg = val[WIDTH_W-1:0];
      REG_GAIN:   gain_reg   = val[GAIN_W-1:0];
      default: begin
      end
    endcase
    settings_used++;
  endtask

  task automatic program_all(int period, int center, int gain);
    program_reg(REG_PERIOD, CFG_DAT_W'(period));
    program_reg(REG_CENTER, CFG_DAT_W'(center));
    program_reg(REG_GAIN, CFG_DAT_W'(gain));
  endtask

  // Status codes and staging rules at the reset settings.
  task automatic test_item_status();
    send_cmd(make_cmd(MODE_TICK, 0, 0, 1'b0));
    send_cmd(make_cmd(MODE_SET, 0, 0, 1'b0));
    send_cmd(make_cmd(MODE_SET, NUM_CH - 1, PCT_MAX, 1'b0));
    send_cmd(make_cmd(MODE_SET, 1, -PCT_MAX, 1'b0));
    send_cmd(make_cmd(MODE_SET, NUM_CH, 0, 1'b0));
    send_cmd(make_cmd(MODE_SET, 31, -128, 1'b0));
    send_cmd(make_cmd(MODE_SET, 2, PCT_MAX + 1, 1'b0));
    send_cmd(make_cmd(MODE_SET, 3, -PCT_MAX - 1, 1'b0));
    send_cmd(make_cmd(MODE_SET, 4, 127, 1'b1));
    send_cmd(make_cmd(MODE_PUBLISH, 0, 0, 1'b0));
    send_cmd(make_cmd(MODE_UNUSED, 5, 50, 1'b1));
  endtask

  // A short frame, so that rising and falling pin edges and the copy are seen.
  task automatic test_frame_edges();
    program_all(6, 2, 1);
    send_cmd(make_cmd(MODE_SET, 0, 0, 1'b0));
    send_cmd(make_cmd(MODE_SET, 5, 3, 1'b0));
    send_cmd(make_cmd(MODE_SET, NUM_CH - 1, -PCT_MAX, 1'b0));
    send_cmd(make_cmd(MODE_PUBLISH, 0, 0, 1'b0));
    repeat (10) send_cmd(make_cmd(MODE_TICK, 0, 0, 1'b0));
  endtask

  // Degenerate periods, saturation at both ends and the widest register values.
  task automatic test_width_limits();
    program_reg(REG_PERIOD, '0);
    repeat (2) send_cmd(make_cmd(MODE_TICK, 31, -1, 1'b1));
    program_reg(REG_PERIOD, 16'd1);
    repeat (2) send_cmd(make_cmd(MODE_TICK, 0, 0, 1'b0));
    program_reg(REG_SPARE, 16'hFFFF);
    program_reg(REG_CENTER, 16'hFFFF);
    program_reg(REG_GAIN, 16'h000F);
    send_cmd(make_cmd(MODE_SET, 6, PCT_MAX, 1'b0));
    program_reg(REG_CENTER, 16'hF000);
    send_cmd(make_cmd(MODE_SET, 7, -PCT_MAX, 1'b0));
    program_reg(REG_GAIN, '0);
    send_cmd(make_cmd(MODE_SET, 8, 0, 1'b0));
    send_cmd(make_cmd(MODE_SET, 0, 0, 1'b1));
    send_cmd(make_cmd(MODE_PUBLISH, 0, 0, 1'b0));
    program_reg(REG_PERIOD, 16'hFFFF);
    repeat (3) send_cmd(make_cmd(MODE_TICK, 0, 0, 1'b0));
  endtask

  // Random traffic over several register settings, with idling on and off.
  task automatic test_random_frames(int phases, int per_phase);
    int period;
    for (int ph = 0; ph < phases; ph++) begin
      period = $urandom_range(2, 120);
      if (ph == 3)
        program_all(period, $urandom_range(3000, 4095), $urandom_range(10, 15));
      else
        program_all(period, $urandom_range(0, period + 20), $urandom_range(0, 2));
      tx_gaps = (ph != 2);
      rx_gaps = (ph != 1);
      repeat (per_phase) send_cmd(random_cmd());
    end
  endtask

  // The receiver stalls for a long stretch while beats keep coming.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold_len = 250;
    repeat (60) send_cmd(random_cmd());
    wait_drained();
  endtask

  // Back-to-back traffic on both sides to close the run.
  task automatic test_gapless_tail();
    program_all($urandom_range(2, 80), $urandom_range(0, 60), $urandom_range(0, 1));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (200) send_cmd(random_cmd());
  endtask

  // Result receiver: random stall bursts, plus a long hold on request.
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_beats.size() == 0) begin
        report_fault("result beat with nothing awaited", 0, out_pin_levels);
      end else begin
        want_beat = awaited_beats.pop_front();
        if (out_pin_levels !== want_beat.pin_levels)
          report_fault("pin_levels", want_beat.pin_levels, out_pin_levels);
        if (out_frame_start !== want_beat.frame_start)
          report_fault("frame_start", want_beat.frame_start, out_frame_start);
        if (out_status !== want_beat.status)
          report_fault("status", want_beat.status, out_status);
      end
    end
  end

  // Test sequence.
  initial begin : run_tests
    int spin;
    clear_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_item_status();
    test_frame_edges();
    test_width_limits();
    test_random_frames(5, 260);
    test_backpressure();
    test_gapless_tail();

    // Let the last beats drain, then wait once more for stragglers.
    release_input();
    spin = 0;
    while (awaited_beats.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (awaited_beats.size() != 0) begin
      $display("%0d predicted result beats never arrived", awaited_beats.size());
      err_count += awaited_beats.size();
    end

    $display("Sent %0d beats: %0d ticks covering %0d frame starts, %0d rejected settings.",
             items_sent, ticks_sent, frames_seen, rejects_seen);
    $display("Used %0d register writes, including degenerate periods and width saturation.",
             settings_used);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
